>>> rtl/byte_budget_lru_cache_assert.svh
// assertion macros for the byte budget lru cache
`ifndef BYTE_BUDGET_LRU_CACHE_ASSERT_SVH
`define BYTE_BUDGET_LRU_CACHE_ASSERT_SVH

// same-cycle implication
`define BBLC_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBLC_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bblc_pkg.sv
// shared types and constants of the byte budget lru cache
package bblc_pkg;

    localparam int          DEF_ENTRIES  = 64;
    localparam logic [31:0] BUDGET_RESET = 32'd67108864;

    typedef enum logic [1:0] {
        OP_GET   = 2'd0,
        OP_PUT   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_TRIM  = 2'd3
    } op_t;

    typedef struct packed {
        logic latch;
        logic addr_clr;
        logic addr_inc;
        logic find_old;
        logic touch;
        logic drop;
        logic evict;
        logic insert;
        logic clear;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic key_match;
        logic addr_last;
        logic addr_free;
        logic need_evict;
        logic full;
    } status_t;

endpackage

>>> rtl/byte_budget_lru_cache.sv
// top level of the byte budget lru cache
//
// channel   | handshake                       | payload
// ----------+---------------------------------+------------------------------------------
// request   | start, busy (taken: start&!busy)| operation, lookup_key, entry_handle,
//           |                                 | handle_present, entry_bytes
// result    | done (one-cycle strobe)         | hit, found_handle, entry_count,
//           |                                 | bytes_used, evicted_count
// budget    | byte_budget_valid/_ready        | byte_budget
//
// get: key scan over the key memory, slot by slot, then a touch of the entry on a hit
// put with handle_present: key scan that drops a match, then evictions, then a free-slot scan of up
//      to ENTRIES slots and the insert; clear empties the cache, trim evicts until within budget
// the single read port of the entry memories sets the scan rate
// reset empties the cache at once through the valid bits, no clearing pass
// the receiver cannot stall: a result holds on the ports from the done cycle until the next request is taken
module byte_budget_lru_cache
    import bblc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  operation,
    input  logic [63:0] lookup_key,
    input  logic [31:0] entry_handle,
    input  logic        handle_present,
    input  logic [31:0] entry_bytes,
    output logic        done,
    output logic        hit,
    output logic [31:0] found_handle,
    output logic [6:0]  entry_count,
    output logic [31:0] bytes_used,
    output logic [6:0]  evicted_count,
    input  logic        byte_budget_valid,
    output logic        byte_budget_ready,
    input  logic [31:0] byte_budget
);

    localparam int CW = $clog2(ENTRIES + 1);

    cmd_t          cmd;
    status_t       status;
    logic [CW-1:0] total;
    logic [CW-1:0] evicted;
    logic          take;

    // budget register always takes a write
    assign byte_budget_ready = 1'b1;
    assign take              = start && !busy;

    bblc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (take),
        .in_op      (operation),
        .in_present (handle_present),
        .status     (status),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    bblc_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr       (byte_budget_valid),
        .cfg_data     (byte_budget),
        .in_op        (operation),
        .in_key       (lookup_key),
        .in_handle    (entry_handle),
        .in_bytes     (entry_bytes),
        .cmd          (cmd),
        .status       (status),
        .hit          (hit),
        .found_handle (found_handle),
        .total        (total),
        .used         (bytes_used),
        .evicted      (evicted)
    );

    // counts are reported modulo 128
    assign entry_count   = 7'(total);
    assign evicted_count = 7'(evicted);

    `include "byte_budget_lru_cache_assert.svh"

    // a request in flight blocks the next one
    `BBLC_ASSERT_NEXT(a_take_busy, take, busy, "request taken but busy not raised")
    // a result is shown only while the request still holds the block
    `BBLC_ASSERT_NOW(a_done_busy, done, busy, "result strobe outside a request")
    // one result per request
    `BBLC_ASSERT_NEXT(a_done_once, done, !done && !busy, "result strobe longer than a cycle")
    // only a get can report a hit
    `BBLC_ASSERT_NOW(a_hit_get, done && hit, status.op == OP_GET, "hit reported for non-get")

endmodule

>>> rtl/bblc_datapath.sv
// storage, recency lanes and counters of the byte budget lru cache
module bblc_datapath
    import bblc_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr,
    input  logic [31:0]                   cfg_data,
    input  logic [1:0]                    in_op,
    input  logic [63:0]                   in_key,
    input  logic [31:0]                   in_handle,
    input  logic [31:0]                   in_bytes,
    input  cmd_t                          cmd,
    output status_t                       status,
    output logic                          hit,
    output logic [31:0]                   found_handle,
    output logic [$clog2(ENTRIES+1)-1:0]  total,
    output logic [31:0]                   used,
    output logic [$clog2(ENTRIES+1)-1:0]  evicted
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    logic [31:0]         budget_reg;
    op_t                 op_reg;
    logic [63:0]         key_reg;
    logic [31:0]         handle_reg;
    logic [31:0]         bytes_reg;
    logic [AW-1:0]       addr_reg;
    logic [ENTRIES-1:0]  valid_reg;
    logic [AW-1:0]       rank_reg [ENTRIES];
    logic [31:0]         used_reg;
    logic [CW-1:0]       total_reg;
    logic [CW-1:0]       evicted_reg;
    logic                hit_reg;
    logic [31:0]         found_reg;

    logic [63:0]         key_mem    [ENTRIES];
    logic [31:0]         handle_mem [ENTRIES];
    logic [31:0]         size_mem   [ENTRIES];
    logic [63:0]         key_rd_reg;
    logic [31:0]         handle_rd_reg;
    logic [31:0]         size_rd_reg;

    logic [AW-1:0]       rank_sel;
    logic [AW-1:0]       oldest_rank;
    logic [AW-1:0]       oldest_addr;
    logic [32:0]         put_sum;

    assign rank_sel    = rank_reg[addr_reg];
    assign oldest_rank = AW'(total_reg - CW'(1));
    assign put_sum     = {1'b0, used_reg} + {1'b0, bytes_reg};

    // encode the one lane whose rank is the oldest
    always_comb
    begin
        oldest_addr = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (valid_reg[i] && rank_reg[i] == oldest_rank)
            begin
                oldest_addr = oldest_addr | AW'(i);
            end
        end
    end

    always_comb
    begin
        status.op         = op_reg;
        status.key_match  = valid_reg[addr_reg] && (key_rd_reg == key_reg);
        status.addr_last  = (addr_reg == AW'(ENTRIES - 1));
        status.addr_free  = !valid_reg[addr_reg];
        status.full       = (total_reg == CW'(ENTRIES));
        if (op_reg == OP_PUT)
        begin
            status.need_evict = (total_reg != '0) && (put_sum > {1'b0, budget_reg});
        end
        else
        begin
            status.need_evict = (total_reg != '0) && (used_reg > budget_reg);
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg  <= BUDGET_RESET;
            valid_reg   <= '0;
            used_reg    <= '0;
            total_reg   <= '0;
            evicted_reg <= '0;
            hit_reg     <= 1'b0;
            addr_reg    <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                budget_reg <= cfg_data;
            end
            if (cmd.latch)
            begin
                evicted_reg <= '0;
                hit_reg     <= 1'b0;
                addr_reg    <= '0;
            end
            if (cmd.addr_clr)
            begin
                addr_reg <= '0;
            end
            if (cmd.addr_inc)
            begin
                addr_reg <= addr_reg + AW'(1);
            end
            if (cmd.find_old)
            begin
                addr_reg <= oldest_addr;
            end
            if (cmd.touch)
            begin
                hit_reg <= 1'b1;
            end
            if (cmd.drop || cmd.evict)
            begin
                valid_reg[addr_reg] <= 1'b0;
                used_reg            <= used_reg - size_rd_reg;
                total_reg           <= total_reg - CW'(1);
            end
            if (cmd.evict)
            begin
                evicted_reg <= evicted_reg + CW'(1);
            end
            if (cmd.insert)
            begin
                valid_reg[addr_reg] <= 1'b1;
                used_reg            <= used_reg + bytes_reg;
                total_reg           <= total_reg + CW'(1);
            end
            if (cmd.clear)
            begin
                valid_reg <= '0;
                used_reg  <= '0;
                total_reg <= '0;
            end
        end
    end

    // request payload and lookup result
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= op_t'(in_op);
            key_reg    <= in_key;
            handle_reg <= in_handle;
            bytes_reg  <= in_bytes;
            found_reg  <= '0;
        end
        if (cmd.touch)
        begin
            found_reg <= handle_rd_reg;
        end
    end

    // recency lanes, rank 0 is most recent
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (cmd.touch)
            begin
                if (AW'(i) == addr_reg)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i] && rank_reg[i] < rank_sel)
                begin
                    rank_reg[i] <= rank_reg[i] + AW'(1);
                end
            end
            else if (cmd.drop)
            begin
                if (valid_reg[i] && rank_reg[i] > rank_sel)
                begin
                    rank_reg[i] <= rank_reg[i] - AW'(1);
                end
            end
            else if (cmd.insert)
            begin
                if (AW'(i) == addr_reg)
                begin
                    rank_reg[i] <= '0;
                end
                else if (valid_reg[i])
                begin
                    rank_reg[i] <= rank_reg[i] + AW'(1);
                end
            end
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_mem[addr_reg]    <= key_reg;
            handle_mem[addr_reg] <= handle_reg;
            size_mem[addr_reg]   <= bytes_reg;
        end
        key_rd_reg    <= key_mem[addr_reg];
        handle_rd_reg <= handle_mem[addr_reg];
        size_rd_reg   <= size_mem[addr_reg];
    end

    assign hit          = hit_reg;
    assign found_handle = found_reg;
    assign total        = total_reg;
    assign used         = used_reg;
    assign evicted      = evicted_reg;

endmodule

>>> rtl/bblc_ctrl.sv
// request sequencer of the byte budget lru cache
module bblc_ctrl
    import bblc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic [1:0] in_op,
    input  logic    in_present,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLR,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_TOUCH,
        S_DROP,
        S_EV_CHK,
        S_EV_FIND,
        S_EV_RD,
        S_EV_DROP,
        S_FREE,
        S_INSERT,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    case (op_t'(in_op))
                        OP_GET:   state_next = S_SCAN_RD;
                        OP_PUT:   state_next = in_present ? S_SCAN_RD : S_DONE;
                        OP_CLEAR: state_next = S_CLR;
                        default:  state_next = S_EV_CHK;
                    endcase
                end
            end
            S_CLR:
            begin
                cmd.clear  = 1'b1;
                state_next = S_DONE;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (status.key_match)
                begin
                    state_next = (status.op == OP_GET) ? S_TOUCH : S_DROP;
                end
                else if (status.addr_last)
                begin
                    state_next = (status.op == OP_GET) ? S_DONE : S_EV_CHK;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = S_SCAN_RD;
                end
            end
            S_TOUCH:
            begin
                cmd.touch  = 1'b1;
                state_next = S_DONE;
            end
            S_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_EV_CHK;
            end
            S_EV_CHK:
            begin
                if (status.need_evict || (status.op == OP_PUT && status.full))
                begin
                    state_next = S_EV_FIND;
                end
                else if (status.op == OP_PUT)
                begin
                    cmd.addr_clr = 1'b1;
                    state_next   = S_FREE;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_EV_FIND:
            begin
                cmd.find_old = 1'b1;
                state_next   = S_EV_RD;
            end
            S_EV_RD:
            begin
                state_next = S_EV_DROP;
            end
            S_EV_DROP:
            begin
                cmd.evict  = 1'b1;
                state_next = S_EV_CHK;
            end
            S_FREE:
            begin
                if (status.addr_free)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                end
            end
            S_INSERT:
            begin
                cmd.insert = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != S_IDLE);
            done_reg  <= (state_next == S_DONE);
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule
